### hdl/lramt_pkg.sv
// shared types and constants for the lazy range add / range max tree
package lramt_pkg;

    localparam int VALUE_W = 64;
    localparam int TAG_W   = 16;
    localparam int MODE_W  = 2;
    localparam int LEFT_W  = 10;
    localparam int RIGHT_W = 11;

    localparam logic [MODE_W-1:0] MODE_SET = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QRY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALL = 2'd3;

    // datapath commands issued by the sequencer
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_PUSH0,
        OP_PUSH1,
        OP_PUSH2,
        OP_PUSH3,
        OP_PULL0,
        OP_PULL1,
        OP_PULL2,
        OP_ADD0,
        OP_ADD1,
        OP_QRD,
        OP_QL,
        OP_QR,
        OP_LEAF,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

endpackage

### hdl/lazy_range_add_max_tree.sv
// Lazy segment tree with point set, range add and range/whole maximum.
// After reset the block runs a clearing pass over all node addresses with busy
// high. Each word then walks the boundary paths, log2(T) levels deep (T =
// LEAVES rounded up to a power of two): a set pushes pending adds down the
// leaf's path, writes the leaf and pulls the maxima back up; a range add does
// pushes along both boundary paths, then a cover walk that adds to each
// covering node, then the pulls; a range query does the same pushes and cover
// walk and then emits the result; a whole-array query reads the root and
// emits it. A query result shows for one cycle with done high; the receiver
// cannot stall it. start is taken whenever busy is low.
module lazy_range_add_max_tree
    import lramt_pkg::*;
#(
    parameter int LEAVES   = 1024,
    parameter int TAG_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [MODE_W-1:0]         mode,
    input  logic [LEFT_W-1:0]         left_index,
    input  logic signed [RIGHT_W-1:0] right_index,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [TAG_W-1:0]          tag,
    output logic                      busy,
    output logic                      done,
    output logic signed [VALUE_W-1:0] max_value,
    output logic [TAG_W-1:0]          max_tag,
    output logic                      empty_res
);

    localparam int LOG = $clog2(LEAVES);

    dp_cmd_t      cmd;
    logic [LOG:0] addr;

    // sequencer
    lramt_ctrl #(
        .LEAVES (LEAVES),
        .LOG    (LOG)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .left_index  (left_index),
        .right_index (right_index),
        .busy        (busy),
        .cmd         (cmd),
        .addr        (addr)
    );

    // memories and arithmetic
    lramt_dp #(
        .LOG      (LOG),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .addr      (addr),
        .value     (value),
        .tag       (tag),
        .max_value (max_value),
        .max_tag   (max_tag),
        .empty_res (empty_res),
        .done      (done)
    );

endmodule

### hdl/lramt_dp.sv
// node and pending-add memories with the add, compare and result logic
module lramt_dp
    import lramt_pkg::*;
#(
    parameter int LOG      = 10,
    parameter int TAG_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    input  logic [LOG:0]              addr,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [TAG_W-1:0]          tag,
    output logic signed [VALUE_W-1:0] max_value,
    output logic [TAG_W-1:0]          max_tag,
    output logic                      empty_res,
    output logic                      done
);

    localparam int T  = 1 << LOG;
    localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    typedef struct packed {
        logic               p;
        logic [TW-1:0]      t;
        logic [VALUE_W-1:0] v;
    } node_t;

    node_t              node_mem [2*T];
    logic [VALUE_W-1:0] pend_mem [T];

    node_t              node_rd;
    logic [VALUE_W-1:0] pend_rd;

    logic               n_we;
    logic [LOG:0]       n_waddr;
    logic [LOG:0]       n_raddr;
    node_t              n_wdata;
    logic               p_we;
    logic [LOG-1:0]     p_waddr;
    logic [LOG-1:0]     p_raddr;
    logic [VALUE_W-1:0] p_wdata;

    logic [LOG:0]       kc;
    logic [LOG:0]       kc1;
    logic               k_int;
    logic               child_int;

    logic [VALUE_W-1:0] amt_reg;
    node_t              a_reg;
    node_t              sl_reg;
    node_t              sr_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [TW-1:0]      tag_reg;
    node_t              res;
    logic [VALUE_W-1:0] max_value_reg;
    logic [TAG_W-1:0]   max_tag_reg;
    logic               empty_reg;
    logic               done_reg;
    logic               done_next;

    // right wins unless the left candidate is strictly larger
    function automatic node_t pick(node_t a, node_t b);
        node_t r;
        if (!a.p) begin
            r = b;
        end else if (!b.p) begin
            r = a;
        end else if ($signed(a.v) > $signed(b.v)) begin
            r = a;
        end else begin
            r = b;
        end
        return r;
    endfunction

    // child addresses and internal-node tests
    assign kc        = {addr[LOG-1:0], 1'b0};
    assign kc1       = {addr[LOG-1:0], 1'b1};
    assign k_int     = ~addr[LOG];
    assign child_int = ~kc[LOG];
    assign res       = pick(sl_reg, sr_reg);

    // memory port control per command
    always_comb
    begin
        n_raddr = addr;
        p_raddr = addr[LOG-1:0];
        n_we    = 1'b0;
        n_waddr = addr;
        n_wdata = '0;
        p_we    = 1'b0;
        p_waddr = addr[LOG-1:0];
        p_wdata = '0;
        case (cmd.op)
            OP_CLEAR:
            begin
                n_we = 1'b1;
                p_we = k_int;
            end
            OP_PUSH0:
            begin
                n_raddr = kc;
            end
            OP_PUSH1:
            begin
                n_we      = 1'b1;
                n_waddr   = kc;
                n_wdata   = node_rd;
                n_wdata.v = node_rd.v + pend_rd;
                p_we      = 1'b1;
                n_raddr   = kc1;
                p_raddr   = kc[LOG-1:0];
            end
            OP_PUSH2:
            begin
                n_we      = 1'b1;
                n_waddr   = kc1;
                n_wdata   = node_rd;
                n_wdata.v = node_rd.v + amt_reg;
                p_we      = child_int;
                p_waddr   = kc[LOG-1:0];
                p_wdata   = pend_rd + amt_reg;
                p_raddr   = kc1[LOG-1:0];
            end
            OP_PUSH3:
            begin
                p_we    = child_int;
                p_waddr = kc1[LOG-1:0];
                p_wdata = pend_rd + amt_reg;
            end
            OP_PULL0:
            begin
                n_raddr = kc;
            end
            OP_PULL1:
            begin
                n_raddr = kc1;
            end
            OP_PULL2:
            begin
                n_we    = 1'b1;
                n_wdata = pick(a_reg, node_rd);
            end
            OP_ADD1:
            begin
                n_we      = 1'b1;
                n_wdata   = node_rd;
                n_wdata.v = node_rd.v + val_reg;
                p_we      = k_int;
                p_wdata   = pend_rd + val_reg;
            end
            OP_LEAF:
            begin
                n_we    = 1'b1;
                n_wdata = {1'b1, tag_reg, val_reg};
            end
            default:
            begin
            end
        endcase
    end

    // memories, registered read data
    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            node_mem[n_waddr] <= n_wdata;
        end
        if (p_we)
        begin
            pend_mem[p_waddr] <= p_wdata;
        end
        node_rd <= node_mem[n_raddr];
        pend_rd <= pend_mem[p_raddr];
    end

    // working registers and result word
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                val_reg <= value;
                tag_reg <= tag[TW-1:0];
                sl_reg  <= '0;
                sr_reg  <= '0;
            end
            OP_PUSH1:
            begin
                amt_reg <= pend_rd;
            end
            OP_PULL1:
            begin
                a_reg <= node_rd;
            end
            OP_QL:
            begin
                sl_reg <= pick(sl_reg, node_rd);
            end
            OP_QR:
            begin
                sr_reg <= pick(node_rd, sr_reg);
            end
            OP_EMIT:
            begin
                max_value_reg <= res.p ? res.v : '0;
                max_tag_reg   <= res.p ? TAG_W'(res.t) : '0;
                empty_reg     <= ~res.p;
            end
            default:
            begin
            end
        endcase
    end

    // result strobe
    assign done_next = (cmd.op == OP_EMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign max_value = max_value_reg;
    assign max_tag   = max_tag_reg;
    assign empty_res = empty_reg;
    assign done      = done_reg;

endmodule

### hdl/lramt_ctrl.sv
// sequencer: walks the boundary paths and the range cover, issues datapath commands
module lramt_ctrl
    import lramt_pkg::*;
#(
    parameter int LEAVES = 1024,
    parameter int LOG    = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [MODE_W-1:0]         mode,
    input  logic [LEFT_W-1:0]         left_index,
    input  logic signed [RIGHT_W-1:0] right_index,
    output logic                      busy,
    output dp_cmd_t                   cmd,
    output logic [LOG:0]              addr
);

    localparam int T  = 1 << LOG;
    localparam int NW = LOG + 2;
    localparam int LW = $clog2(LOG + 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_PUSH  = 8'b0000_0100,
        S_LEAF  = 8'b0000_1000,
        S_ADD   = 8'b0001_0000,
        S_QRY   = 8'b0010_0000,
        S_PULL  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              force_reg, force_next;
    logic [NW-1:0]     l0_reg, l0_next;
    logic [NW-1:0]     r0_reg, r0_next;
    logic [NW-1:0]     l_reg, l_next;
    logic [NW-1:0]     r_reg, r_next;
    logic [LW-1:0]     lvl_reg, lvl_next;
    logic              side_reg, side_next;
    logic [1:0]        sub_reg, sub_next;
    logic [LOG:0]      clr_reg, clr_next;

    int                right_int;
    int                right_sat;
    logic              range_ok;
    logic              left_ok;
    logic [NW-1:0]     mask;
    logic [NW-1:0]     bnd_node;
    logic              bnd_cond;
    logic [NW-1:0]     r_dec;

    // input decode
    assign right_int = int'(right_index);
    assign right_sat = (right_int > LEAVES - 1) ? LEAVES - 1 : right_int;
    assign range_ok  = (right_sat >= int'(left_index));
    assign left_ok   = (int'(left_index) < LEAVES);

    // boundary path node at the current level
    assign mask     = (NW'(1) << lvl_reg) - NW'(1);
    assign r_dec    = r_reg - NW'(1);
    assign bnd_node = side_reg ? ((r0_reg - NW'(1)) >> lvl_reg) : (l0_reg >> lvl_reg);
    assign bnd_cond = side_reg ? (!force_reg && ((r0_reg & mask) != '0))
                               : (force_reg || ((l0_reg & mask) != '0));

    assign busy = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        force_next = force_reg;
        l0_next    = l0_reg;
        r0_next    = r0_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        lvl_next   = lvl_reg;
        side_next  = side_reg;
        sub_next   = sub_reg;
        clr_next   = clr_reg;
        cmd.op     = OP_NOP;
        addr       = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op   = OP_CLEAR;
                addr     = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (LOG+1)'(2*T - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    mode_next  = mode;
                    lvl_next   = LW'(LOG);
                    side_next  = 1'b0;
                    sub_next   = 2'd0;
                    l0_next    = NW'(left_index) + NW'(T);
                    r0_next    = NW'(right_sat + 1 + T);
                    force_next = 1'b0;
                    case (mode)
                        MODE_SET:
                        begin
                            r0_next    = NW'(left_index) + NW'(T + 1);
                            force_next = 1'b1;
                            if (left_ok)
                            begin
                                state_next = S_PUSH;
                            end
                        end
                        MODE_ALL:
                        begin
                            l_next     = NW'(1);
                            r_next     = NW'(2);
                            state_next = S_QRY;
                        end
                        default:
                        begin
                            if (range_ok)
                            begin
                                state_next = S_PUSH;
                            end
                            else if (mode == MODE_QRY)
                            begin
                                state_next = S_EMIT;
                            end
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                addr = bnd_node[LOG:0];
                if (bnd_cond && sub_reg != 2'd3)
                begin
                    sub_next = sub_reg + 2'd1;
                    case (sub_reg)
                        2'd0:    cmd.op = OP_PUSH0;
                        2'd1:    cmd.op = OP_PUSH1;
                        default: cmd.op = OP_PUSH2;
                    endcase
                end
                else
                begin
                    if (bnd_cond)
                    begin
                        cmd.op = OP_PUSH3;
                    end
                    sub_next = 2'd0;
                    if (!side_reg)
                    begin
                        side_next = 1'b1;
                    end
                    else
                    begin
                        side_next = 1'b0;
                        if (lvl_reg == LW'(1))
                        begin
                            l_next = l0_reg;
                            r_next = r0_reg;
                            case (mode_reg)
                                MODE_SET: state_next = S_LEAF;
                                MODE_ADD: state_next = S_ADD;
                                default:  state_next = S_QRY;
                            endcase
                        end
                        else
                        begin
                            lvl_next = lvl_reg - LW'(1);
                        end
                    end
                end
            end
            S_LEAF:
            begin
                cmd.op     = OP_LEAF;
                addr       = l0_reg[LOG:0];
                lvl_next   = LW'(1);
                side_next  = 1'b0;
                sub_next   = 2'd0;
                state_next = S_PULL;
            end
            S_ADD, S_QRY:
            begin
                if (!side_reg)
                begin
                    addr = l_reg[LOG:0];
                    if (!(l_reg < r_reg))
                    begin
                        lvl_next   = LW'(1);
                        sub_next   = 2'd0;
                        state_next = (state_reg == S_ADD) ? S_PULL : S_EMIT;
                    end
                    else if (l_reg[0] && sub_reg == 2'd0)
                    begin
                        cmd.op   = (state_reg == S_ADD) ? OP_ADD0 : OP_QRD;
                        sub_next = 2'd1;
                    end
                    else
                    begin
                        if (l_reg[0])
                        begin
                            cmd.op = (state_reg == S_ADD) ? OP_ADD1 : OP_QL;
                            l_next = l_reg + NW'(1);
                        end
                        sub_next  = 2'd0;
                        side_next = 1'b1;
                    end
                end
                else
                begin
                    addr = r_dec[LOG:0];
                    if (r_reg[0] && sub_reg == 2'd0)
                    begin
                        cmd.op   = (state_reg == S_ADD) ? OP_ADD0 : OP_QRD;
                        sub_next = 2'd1;
                    end
                    else
                    begin
                        if (r_reg[0])
                        begin
                            cmd.op = (state_reg == S_ADD) ? OP_ADD1 : OP_QR;
                        end
                        sub_next  = 2'd0;
                        side_next = 1'b0;
                        l_next    = l_reg >> 1;
                        r_next    = r_reg >> 1;
                    end
                end
            end
            S_PULL:
            begin
                addr = bnd_node[LOG:0];
                if (bnd_cond && sub_reg != 2'd2)
                begin
                    sub_next = sub_reg + 2'd1;
                    cmd.op   = (sub_reg == 2'd0) ? OP_PULL0 : OP_PULL1;
                end
                else
                begin
                    if (bnd_cond)
                    begin
                        cmd.op = OP_PULL2;
                    end
                    sub_next = 2'd0;
                    if (!side_reg)
                    begin
                        side_next = 1'b1;
                    end
                    else
                    begin
                        side_next = 1'b0;
                        if (lvl_reg == LW'(LOG))
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            lvl_next = lvl_reg + LW'(1);
                        end
                    end
                end
            end
            S_EMIT:
            begin
                cmd.op     = OP_EMIT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            lvl_reg   <= '0;
            side_reg  <= 1'b0;
            sub_reg   <= 2'd0;
            mode_reg  <= MODE_SET;
            force_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            lvl_reg   <= lvl_next;
            side_reg  <= side_next;
            sub_reg   <= sub_next;
            mode_reg  <= mode_next;
            force_reg <= force_next;
        end
    end

    // range bounds
    always_ff @(posedge clk)
    begin
        l0_reg <= l0_next;
        r0_reg <= r0_next;
        l_reg  <= l_next;
        r_reg  <= r_next;
    end

endmodule

### hdl/lramt_chk.sv
// port-level checks for the lazy range add / range max tree
module lramt_chk
    import lramt_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic [MODE_W-1:0]         mode,
    input logic                      busy,
    input logic                      done,
    input logic signed [VALUE_W-1:0] max_value,
    input logic [TAG_W-1:0]          max_tag,
    input logic                      empty_res
);

    // empty result carries zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && empty_res |-> max_value == '0 && max_tag == '0)
        else $error("empty result with nonzero fields");

    // a query always starts work
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (mode == MODE_QRY || mode == MODE_ALL) |=> busy)
        else $error("query word not taken into work");

    // a result only follows work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    // clearing pass after reset
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> busy)
        else $error("not busy during clearing pass");

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held");

endmodule

bind lazy_range_add_max_tree lramt_chk u_chk (.*);
